### src/msl_pkg.sv
// Shared types and constants of the motor slew limiter.
package msl_pkg;

  localparam int PORT_W  = 4;
  localparam int POWER_W = 8;
  localparam int LIMIT_W = 8;
  localparam int CFG_W   = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_RISE_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FALL_LIMIT = 1'd1;

  localparam logic [LIMIT_W-1:0] RISE_LIMIT_RST = 8'd20;
  localparam logic [LIMIT_W-1:0] FALL_LIMIT_RST = 8'd20;

  localparam logic CMD_SET  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;

  typedef struct packed {
    logic                      cmd;
    logic [PORT_W-1:0]         port;
    logic signed [POWER_W-1:0] value;
  } msl_op_t;

  typedef struct packed {
    logic push;
    logic full;
  } msl_push_t;

  typedef struct packed {
    logic pop;
    logic empty;
  } msl_pop_t;

endpackage

### src/msl_front.sv
// Front stage: accept input words, drop out-of-range requests, feed the queue.
module msl_front #(
  parameter int CHANNELS = 10
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_cmd,
  input  logic [msl_pkg::PORT_W-1:0]         in_port,
  input  logic signed [msl_pkg::POWER_W-1:0] in_request_value,
  output msl_pkg::msl_op_t                   op_o,
  output msl_pkg::msl_push_t                 push_o,
  input  logic                               q_full
);
  import msl_pkg::*;

  localparam logic [6:0] CH_LIM = 7'(CHANNELS);

  logic    f_v_r, f_v_nxt;
  msl_op_t f_op_r;
  logic    accept;
  logic    keep;

  assign in_stall = f_v_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign keep     = (in_cmd == CMD_TICK) || ({3'b000, in_port} < CH_LIM);

  always_comb begin
    f_v_nxt = f_v_r;
    if (f_v_r && !q_full) begin
      f_v_nxt = 1'b0;
    end
    if (accept && keep) begin
      f_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else begin
      f_v_r <= f_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      f_op_r.cmd   <= in_cmd;
      f_op_r.port  <= in_port;
      f_op_r.value <= in_request_value;
    end
  end

  assign op_o        = f_op_r;
  assign push_o.push = f_v_r && !q_full;
  assign push_o.full = q_full;

endmodule

### src/msl_queue.sv
// Two-word queue between the front and back stages.
module msl_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  msl_pkg::msl_op_t   wr_op,
  input  msl_pkg::msl_push_t push_i,
  output logic               full,
  output msl_pkg::msl_op_t   rd_op,
  output logic               empty,
  input  logic               pop
);
  import msl_pkg::*;

  msl_op_t           q_mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push_i.push && !push_i.full;
  assign do_pop  = pop && !empty;
  assign rd_op   = q_mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    unique case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem_r[wr_ptr_r] <= wr_op;
    end
  end

endmodule

### src/msl_back.sv
// Back stage: store requests, sweep channels on a tick, limit and emit settings.
module msl_back #(
  parameter int CHANNELS = 10
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  msl_pkg::msl_op_t                   op_i,
  input  msl_pkg::msl_pop_t                  q_i,
  output logic                               pop_o,
  input  logic [msl_pkg::LIMIT_W-1:0]        rise_limit,
  input  logic [msl_pkg::LIMIT_W-1:0]        fall_limit,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [msl_pkg::PORT_W-1:0]         out_port,
  output logic signed [msl_pkg::POWER_W-1:0] out_power,
  output logic                               out_last
);
  import msl_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

  logic signed [POWER_W-1:0] req_mem [CHANNELS];
  logic signed [POWER_W-1:0] app_mem [CHANNELS];
  logic [CHANNELS-1:0]       req_vld_r;
  logic [CHANNELS-1:0]       app_vld_r;

  logic                      busy_r;
  logic [IDX_W-1:0]          rd_idx_r;
  logic                      calc_v_r;
  logic [IDX_W-1:0]          calc_idx_r;
  logic signed [POWER_W-1:0] req_q_r, app_q_r;
  logic                      req_qv_r, app_qv_r;

  logic                      out_v_r;
  logic [PORT_W-1:0]         out_port_r;
  logic signed [POWER_W-1:0] out_power_r;
  logic                      out_last_r;

  logic                      take, set_wr, issue, calc_adv;
  logic [IDX_W-1:0]          set_idx;
  logic signed [9:0]         req_x, app_x, delta, rise_x, fall_x, new_x;

  assign take     = !busy_r && !calc_v_r && !q_i.empty;
  assign pop_o    = take;
  assign set_wr   = q_i.pop && (op_i.cmd == CMD_SET);
  assign set_idx  = IDX_W'(op_i.port);
  assign calc_adv = calc_v_r && (!out_v_r || !out_stall);
  assign issue    = busy_r && (!calc_v_r || calc_adv);

  always_comb begin
    req_x  = req_qv_r ? 10'(req_q_r) : '0;
    app_x  = app_qv_r ? 10'(app_q_r) : '0;
    rise_x = signed'({2'b00, rise_limit});
    fall_x = signed'({2'b00, fall_limit});
    delta  = req_x - app_x;
    priority if (delta > rise_x) begin
      new_x = app_x + rise_x;
    end else if (delta < -fall_x) begin
      new_x = app_x - fall_x;
    end else begin
      new_x = req_x;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      rd_idx_r  <= '0;
      calc_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
      req_vld_r <= '0;
      app_vld_r <= '0;
    end else begin
      if (q_i.pop && (op_i.cmd == CMD_TICK)) begin
        busy_r   <= 1'b1;
        rd_idx_r <= '0;
      end else if (issue) begin
        if (rd_idx_r == LAST_IDX) begin
          busy_r <= 1'b0;
        end else begin
          rd_idx_r <= rd_idx_r + 1'b1;
        end
      end
      if (issue) begin
        calc_v_r <= 1'b1;
      end else if (calc_adv) begin
        calc_v_r <= 1'b0;
      end
      if (calc_adv) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
      if (set_wr) begin
        req_vld_r[set_idx] <= 1'b1;
      end
      if (calc_adv) begin
        app_vld_r[calc_idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (set_wr) begin
      req_mem[set_idx] <= op_i.value;
    end
    if (issue) begin
      req_q_r <= req_mem[rd_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (calc_adv) begin
      app_mem[calc_idx_r] <= new_x[POWER_W-1:0];
    end
    if (issue) begin
      app_q_r <= app_mem[rd_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      calc_idx_r <= rd_idx_r;
      req_qv_r   <= req_vld_r[rd_idx_r];
      app_qv_r   <= app_vld_r[rd_idx_r];
    end
    if (calc_adv) begin
      out_port_r  <= PORT_W'(calc_idx_r);
      out_power_r <= new_x[POWER_W-1:0];
      out_last_r  <= (calc_idx_r == LAST_IDX);
    end
  end

  assign out_valid = out_v_r;
  assign out_port  = out_port_r;
  assign out_power = out_power_r;
  assign out_last  = out_last_r;

endmodule

### src/multichannel_motor_slew_limiter_core.sv
// Top level of the multichannel motor slew limiter: limit registers and stage wiring.
//
// Input channel (in_valid / in_stall): a word with in_cmd low stores
// in_request_value as the request of channel in_port and gives no result;
// ports at or above CHANNELS are dropped. A word with in_cmd high is a tick.
// Result channel (out_valid / out_stall): a tick gives CHANNELS words, one per
// channel from 0 upward, each the new applied setting; out_last marks the end.
// Configuration: cfg_we writes cfg_data to the rise limit (index 0) or the
// fall limit (index 1). The user must write them only while the block is
// idle; the block itself does not enforce it. A taken tick passes the front
// register and queue; its pop sets the back stage busy, each channel is read
// into the calculation registers and its limited setting is registered into
// the output word. A tick then gives one result per cycle while the receiver
// accepts; the single read port of each back-stage channel store sets the rate.
// Reset clears all requests and applied settings to zero and loads both
// limits with 20. A stall on the result side holds the output word; the
// two-word queue and front register keep accepting until they fill.
module multichannel_motor_slew_limiter_core #(
  parameter int CHANNELS = 10
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_cmd,
  input  logic [msl_pkg::PORT_W-1:0]           in_port,
  input  logic signed [msl_pkg::POWER_W-1:0]   in_request_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [msl_pkg::PORT_W-1:0]           out_port,
  output logic signed [msl_pkg::POWER_W-1:0]   out_power,
  output logic                                 out_last,
  input  logic                                 cfg_we,
  input  logic [msl_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [msl_pkg::CFG_W-1:0]            cfg_data
);
  import msl_pkg::*;

  logic [LIMIT_W-1:0] rise_limit_r, fall_limit_r;
  msl_op_t            f_op, q_op;
  msl_push_t          push;
  msl_pop_t           qpop;
  logic               q_full, q_empty, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_limit_r <= RISE_LIMIT_RST;
      fall_limit_r <= FALL_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RISE_LIMIT: rise_limit_r <= cfg_data;
        CFG_FALL_LIMIT: fall_limit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  msl_front #(.CHANNELS(CHANNELS)) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_port          (in_port),
    .in_request_value (in_request_value),
    .op_o             (f_op),
    .push_o           (push),
    .q_full           (q_full)
  );

  msl_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_op  (f_op),
    .push_i (push),
    .full   (q_full),
    .rd_op  (q_op),
    .empty  (q_empty),
    .pop    (q_pop)
  );

  assign qpop.pop   = q_pop;
  assign qpop.empty = q_empty;

  msl_back #(.CHANNELS(CHANNELS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .op_i       (q_op),
    .q_i        (qpop),
    .pop_o      (q_pop),
    .rise_limit (rise_limit_r),
    .fall_limit (fall_limit_r),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_port   (out_port),
    .out_power  (out_power),
    .out_last   (out_last)
  );

endmodule

### sim/msl_checker.sv
// Checker for the motor slew limiter: predicts each result word and compares it.
module msl_checker #(
  parameter int CHANNELS = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                in_cmd,
  input  logic [msl_pkg::PORT_W-1:0]          in_port,
  input  logic signed [msl_pkg::POWER_W-1:0]  in_request_value,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [msl_pkg::PORT_W-1:0]          out_port,
  input  logic signed [msl_pkg::POWER_W-1:0]  out_power,
  input  logic                                out_last,
  input  logic                                cfg_we,
  input  logic [msl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [msl_pkg::CFG_W-1:0]           cfg_data,
  output int                                  mismatches,
  output int                                  settings_due
);
  import msl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [PORT_W-1:0]         port;
    logic signed [POWER_W-1:0] power;
    logic                      last;
  } setting_t;

  setting_t                  due_settings[$];
  logic signed [POWER_W-1:0] requested[CHANNELS];
  logic signed [POWER_W-1:0] applied[CHANNELS];
  logic [LIMIT_W-1:0]        rise_lim;
  logic [LIMIT_W-1:0]        fall_lim;
  int                        fails = 0;
  int                        due_count = 0;

  assign mismatches   = fails;
  assign settings_due = due_count;

  task automatic slew_channels();
    int       delta;
    setting_t s;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      delta = int'(requested[ch]) - int'(applied[ch]);
      if (delta > int'(rise_lim)) begin
        applied[ch] = POWER_W'(int'(applied[ch]) + int'(rise_lim));
      end else if (delta < -int'(fall_lim)) begin
        applied[ch] = POWER_W'(int'(applied[ch]) - int'(fall_lim));
      end else begin
        applied[ch] = requested[ch];
      end
      s.port  = PORT_W'(ch);
      s.power = applied[ch];
      s.last  = (ch == CHANNELS - 1);
      due_settings.push_back(s);
    end
  endtask

  always @(posedge clk) begin
    setting_t want;
    if (!rst_n) begin
      due_settings.delete();
      for (int ch = 0; ch < CHANNELS; ch++) begin
        requested[ch] = '0;
        applied[ch]   = '0;
      end
      rise_lim = RISE_LIMIT_RST;
      fall_lim = FALL_LIMIT_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_RISE_LIMIT: rise_lim = cfg_data;
          CFG_FALL_LIMIT: fall_lim = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (due_settings.size() == 0) begin
          $error("result word with nothing due: out_port %0d, power %0d", out_port, out_power);
          fails++;
        end else begin
          want = due_settings.pop_front();
          if (out_port !== want.port) begin
            $error("out_port: expected %0d, got %0d", want.port, out_port);
            fails++;
          end
          if (out_power !== want.power) begin
            $error("power: expected %0d, got %0d", want.power, out_power);
            fails++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_last);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_cmd == CMD_TICK) begin
          slew_channels();
        end else if (int'(in_port) < CHANNELS) begin
          requested[in_port] = in_request_value;
        end
      end
    end
    due_count <= due_settings.size();
  end

endmodule

### sim/tb.sv
// Testbench top: drives requests, ticks and limit writes into the slew limiter.
module tb;
  import msl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHANNELS = 10;
  localparam int SETTLE   = 20;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      in_cmd = CMD_SET;
  logic [PORT_W-1:0]         in_port = '0;
  logic signed [POWER_W-1:0] in_request_value = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [PORT_W-1:0]         out_port;
  logic signed [POWER_W-1:0] out_power;
  logic                      out_last;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = CFG_RISE_LIMIT;
  logic [CFG_W-1:0]          cfg_data = '0;
  int                        mismatches;
  int                        settings_due;
  logic                      sender_calm = 1'b0;
  logic                      stall_on = 1'b1;
  logic                      hold_results = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  multichannel_motor_slew_limiter_core #(.CHANNELS(CHANNELS)) dut (.*);

  msl_checker #(.CHANNELS(CHANNELS)) checker_i (.*);

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int stall_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  initial begin : receiver
    int n;
    forever begin
      @(posedge clk);
      if (hold_results) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_results = 1'b0;
        out_stall <= 1'b0;
      end else if (stall_on && $urandom_range(0, 99) < 30) begin
        n = stall_len();
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_word(input logic cmd, input logic [PORT_W-1:0] port,
                           input logic signed [POWER_W-1:0] value);
    int n;
    in_valid         <= 1'b1;
    in_cmd           <= cmd;
    in_port          <= port;
    in_request_value <= value;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    n = sender_calm ? 0 : pause_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic await_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (settings_due != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic drain();
    await_results();
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_limits(input logic [CFG_W-1:0] rise, input logic [CFG_W-1:0] fall);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_RISE_LIMIT;
    cfg_data  <= rise;
    @(posedge clk);
    cfg_index <= CFG_FALL_LIMIT;
    cfg_data  <= fall;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 22) begin
      send_word(CMD_TICK, PORT_W'($urandom_range(0, 15)), POWER_W'($urandom));
    end else if (r < 92) begin
      send_word(CMD_SET, PORT_W'($urandom_range(0, CHANNELS - 1)), POWER_W'($urandom));
    end else begin
      send_word(CMD_SET, PORT_W'($urandom_range(CHANNELS, 15)), POWER_W'($urandom));
    end
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(CMD_SET, 4'd0, 8'sd127);
    send_word(CMD_SET, 4'd9, 8'sh80);
    send_word(CMD_SET, 4'd4, -8'sd1);
    send_word(CMD_SET, 4'd5, 8'sd1);
    send_word(CMD_SET, 4'd10, 8'sd99);
    send_word(CMD_SET, 4'd15, 8'sh80);
    send_word(CMD_TICK, 4'd15, -8'sd1);
    send_word(CMD_TICK, 4'd0, 8'sd127);
    send_word(CMD_SET, 4'd0, -8'sd127);
    send_word(CMD_TICK, 4'd9, 8'sh80);
    send_word(CMD_TICK, 4'd3, 8'sd0);
    drain();
    set_limits(8'd0, 8'd0);
    send_word(CMD_SET, 4'd1, 8'sd50);
    send_word(CMD_TICK, 4'd0, 8'sd0);
    send_word(CMD_SET, 4'd1, 8'sd0);
    send_word(CMD_TICK, 4'd0, 8'sd0);
    drain();
    set_limits(8'd254, 8'd254);
    send_word(CMD_SET, 4'd2, 8'sd127);
    send_word(CMD_SET, 4'd3, 8'sh80);
    send_word(CMD_TICK, 4'd7, 8'sd5);
    send_word(CMD_SET, 4'd2, 8'sh80);
    send_word(CMD_SET, 4'd3, 8'sd127);
    send_word(CMD_TICK, 4'd12, -8'sd5);
    send_word(CMD_TICK, 4'd1, 8'sd1);
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_limits(8'd0, 8'd254);
        1: set_limits(8'd254, 8'd0);
        3: set_limits(8'd1, 8'd1);
        default: set_limits(CFG_W'($urandom_range(0, 254)), CFG_W'($urandom_range(0, 254)));
      endcase
      sender_calm = (p == 2) || (p == 3);
      stall_on    = (p != 3);
      if (p == 2) hold_results = 1'b1;
      for (int i = 0; i < 65; i++) begin
        if (p == 2 && i == 40) sender_calm = 1'b0;
        if (p == 4 && i == 32) await_results();
        random_word();
      end
      drain();
    end

    if (mismatches == 0 && settings_due == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
